/* rtl/core/sbbf_pkg.sv */
`timescale 1ns / 1ps

package sbbf_pkg;

  localparam int unsigned WORDS        = 8;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned BLOCK_W      = WORDS * WORD_W;
  localparam int unsigned HASH_W       = 64;
  localparam int unsigned HALF_W       = 32;
  localparam int unsigned BIT_SHIFT    = 27;
  localparam int unsigned NUM_BLOCKS_W = 11;

  localparam int unsigned DEFAULT_MAX_BLOCKS = 1024;
  localparam logic [NUM_BLOCKS_W-1:0] NUM_BLOCKS_RESET = 11'd1024;

  localparam logic [WORD_W-1:0] SALTS [WORDS] = '{
    32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
    32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
  };

  // One bit per 32-bit word, chosen by the top bits of the salted product
  function automatic logic [BLOCK_W-1:0] make_mask(input logic [HALF_W-1:0] low);
    logic [BLOCK_W-1:0] mask;
    logic [WORD_W-1:0]  prod;
    logic [4:0]         sel;
    mask = '0;
    for (int i = 0; i < WORDS; i++) begin
      prod = low * SALTS[i];
      sel  = prod[WORD_W-1:BIT_SHIFT];
      mask[i*WORD_W +: WORD_W] = WORD_W'(1) << sel;
    end
    return mask;
  endfunction

endpackage

/* rtl/core/sbbf_in_if.sv */
`timescale 1ns / 1ps

interface sbbf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [sbbf_pkg::HASH_W-1:0] key_hash;

  modport source (output valid, output op, output key_hash, input ready);
  modport sink (input valid, input op, input key_hash, output ready);
endinterface

/* rtl/core/sbbf_out_if.sv */
`timescale 1ns / 1ps

interface sbbf_out_if;
  logic valid;
  logic ready;
  logic maybe_present;

  modport source (output valid, output maybe_present, input ready);
  modport sink (input valid, input maybe_present, output ready);
endinterface

/* rtl/core/sbbf_ram.sv */
`timescale 1ns / 1ps

module sbbf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sbbf_hash.sv */
`timescale 1ns / 1ps

module sbbf_hash #(
  parameter int unsigned MaxBlocks = sbbf_pkg::DEFAULT_MAX_BLOCKS,
  localparam int unsigned AddrW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1
) (
  input  logic                              clk_i,
  input  logic                              load_i,
  input  logic [sbbf_pkg::NUM_BLOCKS_W-1:0] num_blocks_i,
  input  logic [sbbf_pkg::HASH_W-1:0]       key_hash_i,
  output logic [AddrW-1:0]                  blk_idx_o,
  output logic [sbbf_pkg::BLOCK_W-1:0]      mask_o
);
  import sbbf_pkg::*;

  localparam int unsigned ProdW = HALF_W + NUM_BLOCKS_W;

  logic [31:0]             max32;
  logic [NUM_BLOCKS_W-1:0] n_eff;
  logic [ProdW-1:0]        prod;
  logic [31:0]             idx32;
  logic [AddrW-1:0]        idx_d, idx_q;
  logic [BLOCK_W-1:0]      mask_d, mask_q;

  // Multiply-shift range reduction; count saturates at the store depth
  always_comb begin
    max32 = 32'(MaxBlocks);
    n_eff = (32'(num_blocks_i) > max32) ? NUM_BLOCKS_W'(MaxBlocks) : num_blocks_i;
    prod  = ProdW'(key_hash_i[HASH_W-1:HALF_W]) * ProdW'(n_eff);
    idx32 = 32'(prod[ProdW-1:HALF_W]);
    if (idx32 >= max32) begin
      idx32 = max32 - 32'd1;
    end
    idx_d  = idx32[AddrW-1:0];
    mask_d = make_mask(key_hash_i[HALF_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      idx_q  <= idx_d;
      mask_q <= mask_d;
    end
  end

  assign blk_idx_o = idx_q;
  assign mask_o    = mask_q;

endmodule

/* rtl/core/split_block_bloom_filter_unit.sv */
// Steps: hash register, block read, then read-modify-write or compare on the
// single block memory port; the compare waits while the output is stalled, and
// its result is registered. A new item is taken only once the unit is back in idle.
// Reset: asynchronous, active low; afterwards a clearing pass writes zeros to
// all MAX_BLOCKS blocks, one per cycle, with the input not ready meanwhile.
// num_blocks resets to 1024 and may be written at any time.
`timescale 1ns / 1ps

module split_block_bloom_filter_unit #(
  parameter int unsigned MAX_BLOCKS = sbbf_pkg::DEFAULT_MAX_BLOCKS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sbbf_pkg::NUM_BLOCKS_W-1:0] cfg_wdata_i,
  sbbf_in_if.sink                           req_i,
  sbbf_out_if.source                        rsp_o
);
  import sbbf_pkg::*;

  localparam int unsigned AddrW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_BLOCKS - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_CHECK = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [AddrW-1:0]        clr_cnt_q, clr_cnt_d;
  logic [NUM_BLOCKS_W-1:0] num_blocks_q;
  logic                    op_q;
  logic                    out_valid_q, out_valid_d;
  logic                    maybe_q, maybe_d;

  logic                    accept;
  logic [AddrW-1:0]        blk_idx;
  logic [BLOCK_W-1:0]      mask;
  logic [BLOCK_W-1:0]      rdata;
  logic                    ram_en, ram_we;
  logic [AddrW-1:0]        ram_addr;
  logic [BLOCK_W-1:0]      ram_wdata;
  logic                    slot_free;

  assign accept    = req_i.valid && req_i.ready;
  assign slot_free = !out_valid_q || rsp_o.ready;

  sbbf_hash #(
    .MaxBlocks(MAX_BLOCKS)
  ) u_hash (
    .clk_i       (clk_i),
    .load_i      (accept),
    .num_blocks_i(num_blocks_q),
    .key_hash_i  (req_i.key_hash),
    .blk_idx_o   (blk_idx),
    .mask_o      (mask)
  );

  sbbf_ram #(
    .Width(BLOCK_W),
    .Depth(MAX_BLOCKS)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    maybe_d     = maybe_q;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = blk_idx;
    ram_wdata   = rdata | mask;
    unique case (state_q)
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        ram_en  = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!op_q) begin
          // insert: write the block back with the mask ORed in
          ram_en  = 1'b1;
          ram_we  = 1'b1;
          state_d = S_IDLE;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          maybe_d     = ((rdata & mask) == mask);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      num_blocks_q <= NUM_BLOCKS_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        num_blocks_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    maybe_q <= maybe_d;
    if (accept) begin
      op_q <= req_i.op;
    end
  end

  assign req_i.ready         = (state_q == S_IDLE);
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.maybe_present = maybe_q;

endmodule
